@@ rtl/core/yaz0_pkg.sv @@
// Shared types and constants for the Yaz0 decompressor core.
// No dependencies; imported by yaz0_ctrl, yaz0_dp and yaz0_decompressor_core.
package yaz0_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int HEADER_BYTES = 16;
    localparam int HDR_W        = 5;
    localparam int DIST_W       = 13;
    localparam int LEN_W        = 9;
    localparam int SIZE_W       = 32;
    localparam int OUT_W        = 64;
    localparam int CNT_W        = 4;
    localparam int M_TDATA_W    = 72;

    localparam logic [7:0] LIT_FLAG_MASK = 8'h80;
    localparam logic [7:0] LONG_LEN_BIAS = 8'h12;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TOKEN,
        PH_REF2,
        PH_REF3
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CP_RD,
        ST_CP_WR,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;     // take the input item and decode it
        logic rd;         // issue a history read for the next copy byte
        logic wr;         // store and pack the byte read last cycle
        logic flush;      // move the pack buffer to the output register
        logic flush_last; // the flushed item closes the input item's run
    } dp_cmd_t;

    typedef struct packed {
        logic go_copy;    // accepted item starts a back-reference copy
        logic go_lit;     // accepted item produced a literal byte
        logic pk_full;    // pack buffer holds eight bytes
        logic out_free;   // output register can load this cycle
        logic copy_one;   // one copy byte left
    } dp_stat_t;

endpackage

@@ rtl/core/yaz0_ctrl.sv @@
// Sequencer for the Yaz0 decompressor: accept, copy read/write, flush.
// Depends on yaz0_pkg.
module yaz0_ctrl import yaz0_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  dp_stat_t    stat,
    output dp_cmd_t     cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (stat.go_copy) begin
                        state_next = ST_CP_RD;
                    end else if (stat.go_lit) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_CP_RD: begin
                if (!stat.pk_full) begin
                    state_next = ST_CP_WR;
                end
            end
            ST_CP_WR: begin
                state_next = stat.copy_one ? ST_FLUSH : ST_CP_RD;
            end
            ST_FLUSH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_CP_RD: begin
                // drain a full pack buffer before reading more
                cmd.rd    = !stat.pk_full;
                cmd.flush = stat.pk_full && stat.out_free;
            end
            ST_CP_WR: begin
                cmd.wr = 1'b1;
            end
            ST_FLUSH: begin
                cmd.flush      = stat.out_free;
                cmd.flush_last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/core/yaz0_dp.sv @@
// Datapath for the Yaz0 decompressor: token decode, history window,
// byte packing and output register. Depends on yaz0_pkg.
module yaz0_dp import yaz0_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [SIZE_W-1:0]      cfg_wdata,
    input  logic [7:0]             in_byte,
    input  logic                   in_first,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [OUT_W-1:0]       out_bytes,
    output logic [CNT_W-1:0]       out_cnt,
    output logic                   out_last,
    output logic                   out_done
);

    localparam phase_t START_PHASE = (HEADER_BYTES > 0) ? PH_TOKEN : PH_TOKEN;
    localparam phase_t RST_PHASE   = (HEADER_BYTES > 0) ? PH_HEADER : PH_TOKEN;

    logic [7:0]        hist [WINDOW_DEPTH];
    logic [7:0]        q_reg;
    logic              rdv_reg;

    logic [SIZE_W-1:0] osize_reg;
    logic [WIN_AW-1:0] wp_reg, wp_next;
    logic              wrap_reg, wrap_next;
    logic [SIZE_W-1:0] prod_reg, prod_next;
    logic [HDR_W-1:0]  hc_reg, hc_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        flags_reg, flags_next;
    logic [3:0]        fl_reg, fl_next;
    logic [3:0]        nib_reg, nib_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              fin_reg, fin_next;
    logic [LEN_W-1:0]  left_reg, left_next;

    logic [OUT_W-1:0]  pk_reg, pk_next;
    logic [CNT_W-1:0]  pkc_reg, pkc_next;
    logic              mv_reg;
    logic [OUT_W-1:0]  mdat_reg;
    logic [CNT_W-1:0]  mcnt_reg;
    logic              mlast_reg, mdone_reg;

    // state as seen by the accepted item, after an optional restart
    logic [WIN_AW-1:0] wp_e;
    logic              wrap_e, fin_e;
    logic [SIZE_W-1:0] prod_e, remain;
    logic [HDR_W-1:0]  hc_e;
    phase_t            phase_e;
    logic [7:0]        flags_e;
    logic [3:0]        fl_e, nib_e;
    logic [DIST_W-1:0] dist_e, dist_ref;
    logic [LEN_W-1:0]  len_req, len_eff;
    logic              lit_go, copy_go, use_flag;
    logic [WIN_AW-1:0] src;
    logic [7:0]        wbyte;
    logic              do_write;

    assign wp_e    = in_first ? '0 : wp_reg;
    assign wrap_e  = in_first ? 1'b0 : wrap_reg;
    assign fin_e   = in_first ? 1'b0 : fin_reg;
    assign prod_e  = in_first ? '0 : prod_reg;
    assign hc_e    = in_first ? '0 : hc_reg;
    assign phase_e = in_first ? RST_PHASE : phase_reg;
    assign flags_e = in_first ? '0 : flags_reg;
    assign fl_e    = in_first ? '0 : fl_reg;
    assign nib_e   = in_first ? '0 : nib_reg;
    assign dist_e  = in_first ? '0 : dist_reg;
    assign remain  = osize_reg - prod_e;
    assign dist_ref = (dist_e | DIST_W'(in_byte)) + DIST_W'(1);

    always_comb begin
        lit_go   = 1'b0;
        copy_go  = 1'b0;
        use_flag = 1'b0;
        len_req  = '0;
        len_eff  = '0;
        hc_next    = hc_e;
        phase_next = phase_e;
        flags_next = flags_e;
        fl_next    = fl_e;
        nib_next   = nib_e;
        dist_next  = dist_e;
        fin_next   = fin_e;
        if (!fin_e) begin
            if (prod_e >= osize_reg) begin
                fin_next = 1'b1;
            end else begin
                case (phase_e)
                    PH_HEADER: begin
                        hc_next = hc_e + HDR_W'(1);
                        if ({1'b0, hc_e} + (HDR_W+1)'(1) >= (HDR_W+1)'(HEADER_BYTES)) begin
                            phase_next = START_PHASE;
                        end
                    end
                    PH_TOKEN: begin
                        if (fl_e == 4'd0) begin
                            flags_next = in_byte;
                            fl_next    = 4'd8;
                        end else if ((flags_e & LIT_FLAG_MASK) != 8'd0) begin
                            lit_go   = 1'b1;
                            use_flag = 1'b1;
                        end else begin
                            nib_next   = in_byte[7:4];
                            dist_next  = {1'b0, in_byte[3:0], 8'd0};
                            phase_next = PH_REF2;
                        end
                    end
                    PH_REF2: begin
                        dist_next = dist_ref;
                        if (nib_e != 4'd0) begin
                            copy_go  = 1'b1;
                            use_flag = 1'b1;
                            len_req  = LEN_W'(nib_e) + LEN_W'(2);
                        end else begin
                            phase_next = PH_REF3;
                        end
                    end
                    PH_REF3: begin
                        copy_go  = 1'b1;
                        use_flag = 1'b1;
                        len_req  = LEN_W'(in_byte) + LEN_W'(LONG_LEN_BIAS);
                    end
                    default: ;
                endcase
                if (use_flag) begin
                    flags_next = {flags_e[6:0], 1'b0};
                    fl_next    = fl_e - 4'd1;
                    phase_next = PH_TOKEN;
                end
                // trim the copy at the configured size
                if (SIZE_W'(len_req) >= remain) begin
                    len_eff = LEN_W'(remain);
                end else begin
                    len_eff = len_req;
                end
                if (lit_go) begin
                    fin_next = (remain == SIZE_W'(1));
                end else if (copy_go) begin
                    fin_next = (SIZE_W'(len_req) >= remain);
                end
            end
        end
        if (!copy_go) begin
            len_eff = '0;
        end
    end

    assign src = WIN_AW'(({1'b0, wp_reg}) - (WIN_AW+1)'(dist_reg));

    always_comb begin
        wp_next   = wp_reg;
        wrap_next = wrap_reg;
        prod_next = prod_reg;
        left_next = left_reg;
        pk_next   = pk_reg;
        pkc_next  = pkc_reg;
        do_write  = 1'b0;
        wbyte     = rdv_reg ? q_reg : 8'd0;
        if (cmd.accept) begin
            wp_next   = wp_e;
            wrap_next = wrap_e;
            prod_next = prod_e;
            left_next = len_eff;
            wbyte     = in_byte;
            do_write  = lit_go;
        end
        if (cmd.wr) begin
            do_write  = 1'b1;
            left_next = left_reg - LEN_W'(1);
        end
        if (cmd.flush) begin
            pk_next  = '0;
            pkc_next = '0;
        end
        if (do_write) begin
            wp_next   = wp_next + WIN_AW'(1);
            // every entry is valid once the pointer rolls over
            wrap_next = wrap_next | (wp_next == '0);
            prod_next = prod_next + SIZE_W'(1);
            pk_next[{pkc_reg[2:0], 3'b000} +: 8] = wbyte;
            pkc_next  = pkc_reg + CNT_W'(1);
        end
    end

    // history window: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (do_write) begin
            hist[wp_next - WIN_AW'(1)] <= wbyte;
        end
        if (cmd.rd) begin
            q_reg   <= hist[src];
            rdv_reg <= wrap_reg || (src < wp_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            osize_reg <= '0;
            wp_reg    <= '0;
            wrap_reg  <= 1'b0;
            prod_reg  <= '0;
            hc_reg    <= '0;
            phase_reg <= RST_PHASE;
            flags_reg <= '0;
            fl_reg    <= '0;
            nib_reg   <= '0;
            dist_reg  <= '0;
            fin_reg   <= 1'b0;
            left_reg  <= '0;
            pk_reg    <= '0;
            pkc_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                osize_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                hc_reg    <= hc_next;
                phase_reg <= phase_next;
                flags_reg <= flags_next;
                fl_reg    <= fl_next;
                nib_reg   <= nib_next;
                dist_reg  <= dist_next;
                fin_reg   <= fin_next;
            end
            wp_reg   <= wp_next;
            wrap_reg <= wrap_next;
            prod_reg <= prod_next;
            left_reg <= left_next;
            pk_reg   <= pk_next;
            pkc_reg  <= pkc_next;
            if (cmd.flush) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.flush) begin
            mdat_reg  <= pk_reg;
            mcnt_reg  <= pkc_reg;
            mlast_reg <= cmd.flush_last;
            mdone_reg <= cmd.flush_last && fin_reg;
        end
    end

    assign stat.go_copy  = copy_go;
    assign stat.go_lit   = lit_go;
    assign stat.pk_full  = pkc_reg[3];
    assign stat.out_free = !mv_reg || m_tready;
    assign stat.copy_one = (left_reg == LEN_W'(1));

    assign m_tvalid  = mv_reg;
    assign out_bytes = mdat_reg;
    assign out_cnt   = mcnt_reg;
    assign out_last  = mlast_reg;
    assign out_done  = mdone_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> (mcnt_reg != '0 && mcnt_reg <= CNT_W'(8)))
        else $error("output item with bad byte count");
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && mdone_reg) |-> mlast_reg)
        else $error("stream end outside a run end");
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr |-> !pkc_reg[3])
        else $error("copy byte into full pack buffer");
    a_copy_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr |-> left_reg != '0)
        else $error("copy write with no bytes left");

endmodule

@@ rtl/core/yaz0_decompressor_core.sv @@
// Yaz0 decompressor core: sequencer plus datapath with 4096-byte history.
// A literal is packed on accept and flushed to the output register in the flush state;
// a copy alternates a history read and a packing write per byte, flushing each full
// 8-byte item on the way. The input takes no new item until the current one is flushed.
// Reset (aresetn low, synchronous) clears size register, decoder and output.
// The window needs no clearing pass: reads ahead of the fill mark return zero.
module yaz0_decompressor_core import yaz0_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: decompressed size
    input  logic                 cfg_we,
    input  logic [SIZE_W-1:0]    cfg_wdata,
    // compressed input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] stream_byte
    input  logic                 s_tuser,   // [0] first_byte
    // decompressed output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [63:0] out_bytes, [67:64] byte_count, rest 0
    output logic                 m_tlast,   // last_of_run
    output logic                 m_tuser    // [0] stream_done
);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [OUT_W-1:0] out_bytes;
    logic [CNT_W-1:0] out_cnt;

    yaz0_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    yaz0_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_tdata),
        .in_first  (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_bytes (out_bytes),
        .out_cnt   (out_cnt),
        .out_last  (m_tlast),
        .out_done  (m_tuser)
    );

    // pad the payload out to whole bytes
    assign m_tdata = {{(M_TDATA_W - OUT_W - CNT_W){1'b0}}, out_cnt, out_bytes};

endmodule
